FILE: hdl/deqs_pkg.sv
// ----------------------------------------------------------------------------
// Deque with value search: shared types
// Request and status codes, the controller state, and the result beat layout.
// ----------------------------------------------------------------------------
package deqs_pkg;

  localparam int DataW = 32;
  localparam int ReqW  = 3;
  localparam int OccW  = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REMOVE     = 3'd4,
    REQ_CONTAINS   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] popped;
    logic             found;
    logic [OccW-1:0]  occupancy;
  } res_t;

endpackage

FILE: hdl/deqs_ram.sv
// ----------------------------------------------------------------------------
// Deque entry store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module deqs_ram
  import deqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/deqs_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Keeps the ring head and count, sequences pushes, pops, search and the
// gap-closing shift over the entry store, and offers one result per request.
// ----------------------------------------------------------------------------
module deqs_ctrl
  import deqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic [DataW-1:0]         value_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output res_t                     res_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [DataW-1:0]         mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  logic [DataW-1:0]         mem_rdata_i
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LastSlot = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
    return (s == '0) ? LastSlot : s - 1'b1;
  endfunction

  // Both operands are below DEPTH, so one conditional subtract wraps the sum.
  function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [IW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  req_e             req_q, req_d;
  logic [DataW-1:0] val_q, val_d;
  logic [IW-1:0]    rd_slot_q, rd_slot_d;
  logic [CW-1:0]    rd_left_q, rd_left_d;
  logic             pipe_v_q, pipe_v_d;
  logic [IW-1:0]    pipe_slot_q, pipe_slot_d;
  logic [IW-1:0]    wr_slot_q, wr_slot_d;
  res_t             res_q, res_d;
  logic             full, empty, match;
  logic [31:0]      occ_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      pipe_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      pipe_v_q <= pipe_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    val_q       <= val_d;
    rd_slot_q   <= rd_slot_d;
    rd_left_q   <= rd_left_d;
    pipe_slot_q <= pipe_slot_d;
    wr_slot_q   <= wr_slot_d;
    res_q       <= res_d;
  end

  assign full  = (count_q == FullCount);
  assign empty = (count_q == '0);
  assign match = pipe_v_q && (mem_rdata_i == val_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    req_d       = req_q;
    val_d       = val_q;
    rd_slot_d   = rd_slot_q;
    rd_left_d   = rd_left_q;
    pipe_v_d    = 1'b0;
    pipe_slot_d = pipe_slot_q;
    wr_slot_d   = wr_slot_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_slot_q;
    mem_wdata_o = value_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_slot_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d            = req_e'(req_type_i);
          val_d            = value_i;
          res_d.status     = STS_OK;
          res_d.popped     = '0;
          res_d.found      = 1'b0;
          res_d.occupancy  = '0;
          state_d          = S_RESP;
          case (req_e'(req_type_i))
            REQ_PUSH_FRONT: begin
              if (full) begin
                res_d.status = STS_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = slot_dec(head_q);
                head_d      = slot_dec(head_q);
                count_d     = count_q + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              if (full) begin
                res_d.status = STS_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = slot_add(head_q, count_q);
                count_d     = count_q + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (empty) begin
                res_d.status = STS_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                state_d     = S_POP;
              end
            end
            REQ_POP_BACK: begin
              if (empty) begin
                res_d.status = STS_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = slot_add(head_q, count_q - 1'b1);
                state_d     = S_POP;
              end
            end
            REQ_REMOVE, REQ_CONTAINS: begin
              rd_slot_d = head_q;
              rd_left_d = count_q;
              state_d   = S_SCAN;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_POP: begin
        res_d.popped = mem_rdata_i;
        if (req_q == REQ_POP_FRONT) begin
          head_d = slot_inc(head_q);
        end
        count_d = count_q - 1'b1;
        state_d = S_RESP;
      end

      // One read is issued per cycle; its data is compared in the cycle after.
      S_SCAN: begin
        if (match) begin
          res_d.found = 1'b1;
          if (req_q == REQ_REMOVE) begin
            // Entries still unread are exactly those behind the match.
            wr_slot_d = pipe_slot_q;
            rd_slot_d = slot_inc(pipe_slot_q);
            rd_left_d = rd_left_q;
            state_d   = S_SHIFT;
          end else begin
            state_d = S_RESP;
          end
        end else if (rd_left_q != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_slot_q;
          rd_slot_d   = slot_inc(rd_slot_q);
          rd_left_d   = rd_left_q - 1'b1;
          pipe_v_d    = 1'b1;
          pipe_slot_d = rd_slot_q;
        end else if (!pipe_v_q) begin
          res_d.status = STS_NOT_FOUND;
          state_d      = S_RESP;
        end
      end

      // Each entry behind the gap moves one slot toward the front.
      S_SHIFT: begin
        if (pipe_v_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_slot_q;
          mem_wdata_o = mem_rdata_i;
          wr_slot_d   = slot_inc(wr_slot_q);
        end
        if (rd_left_q != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_slot_q;
          rd_slot_d   = slot_inc(rd_slot_q);
          rd_left_d   = rd_left_q - 1'b1;
          pipe_v_d    = 1'b1;
        end else if (!pipe_v_q) begin
          count_d = count_q - 1'b1;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign occ_w = 32'(count_q);

  always_comb begin
    res_o           = res_q;
    res_o.occupancy = occ_w[OccW-1:0];
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count exceeds depth");

  a_head_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastSlot)
    else $error("head slot out of range");

  a_shift_ports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write of the same slot in one cycle");

  a_full_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && full &&
     (req_type_i == REQ_PUSH_FRONT || req_type_i == REQ_PUSH_BACK))
    |=> (count_q == $past(count_q) && head_q == $past(head_q)))
    else $error("push into a full store changed the state");

endmodule

FILE: hdl/deque_with_value_search_unit.sv
// ----------------------------------------------------------------------------
// Deque with value search unit
// Bounded ring deque of signed words with push/pop at both ends, search and
// in-order removal, with a registered result beat.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o    req_type_i, value_i
//   out      output     out_valid_o / out_stall_i  status_o, popped_value_o,
//                                                  found_o, occupancy_o
//
// One request is in work at a time; a pop waits on the registered read data
// of the store. Contains and remove walk the store one entry per cycle, from
// the front; remove then moves each entry behind the match one slot toward
// the front.
// Reset clears head, count, state and valid flags only; the store needs no clearing pass.
// The result register frees the controller while out_stall_i holds a beat.
// ----------------------------------------------------------------------------
module deque_with_value_search_unit
  import deqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ReqW-1:0]         req_type_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] popped_value_o,
  output logic                    found_o,
  output logic [OccW-1:0]         occupancy_o
);

  localparam int IW = $clog2(DEPTH);

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  deqs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  deqs_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new beat when empty or when its beat leaves.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign popped_value_o = out_q.popped;
  assign found_o        = out_q.found;
  assign occupancy_o    = out_q.occupancy;

endmodule

FILE: tb/sv/deque_search_result_check.sv
// ----------------------------------------------------------------------------
// Deque with value search: result checker
// Watches the request and result channels, keeps its own copy of the deque
// contents, predicts one result beat per accepted request and compares every
// accepted result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_search_result_check
  import deqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ReqW-1:0]  req_type_i,
  input  logic [DataW-1:0] value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       status_i,
  input  logic [DataW-1:0] popped_value_i,
  input  logic             found_i,
  input  logic [OccW-1:0]  occupancy_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o,
  output int               full_refusals_o,
  output int               empty_pops_o,
  output int               matches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Front of the deque is index 0.
  logic [DataW-1:0] entries[$];
  res_t             awaited[$];

  int mismatches    = 0;
  int beats_checked = 0;
  int full_refusals = 0;
  int empty_pops    = 0;
  int hit_total     = 0;

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("%0t: result beat %0d: %s is %h, expected %h", $time, beats_checked,
             what, got, want);
    mismatches++;
  endtask

  function automatic res_t apply_request(input logic [ReqW-1:0] req,
                                         input logic [DataW-1:0] v);
    res_t r;
    int   hit;
    r        = '0;
    r.status = STS_OK;
    hit      = -1;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (entries.size() >= DEPTH) begin
          r.status = STS_FULL;
          full_refusals++;
        end else if (req == REQ_PUSH_FRONT) begin
          entries.push_front(v);
        end else begin
          entries.push_back(v);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (entries.size() == 0) begin
          r.status = STS_EMPTY;
          empty_pops++;
        end else if (req == REQ_POP_FRONT) begin
          r.popped = entries.pop_front();
        end else begin
          r.popped = entries.pop_back();
        end
      end
      REQ_REMOVE, REQ_CONTAINS: begin
        // Only the first match seen from the front counts.
        foreach (entries[k]) begin
          if (hit < 0 && entries[k] == v) hit = k;
        end
        if (hit < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          hit_total++;
          if (req == REQ_REMOVE) entries.delete(hit);
        end
      end
      default: begin
      end
    endcase
    r.occupancy = OccW'(entries.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      entries.delete();
      awaited.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        awaited.push_back(apply_request(req_type_i, value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited.size() == 0) begin
          report_mismatch("beat with no request waiting, status", status_i, '0);
        end else begin
          want = awaited.pop_front();
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (popped_value_i !== want.popped) begin
            report_mismatch("popped value", popped_value_i, want.popped);
          end
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (occupancy_i !== want.occupancy) begin
            report_mismatch("occupancy", occupancy_i, want.occupancy);
          end
        end
        beats_checked++;
      end
    end
    pending_o       <= awaited.size();
    fail_count_o    <= mismatches;
    results_o       <= beats_checked;
    full_refusals_o <= full_refusals;
    empty_pops_o    <= empty_pops;
    matches_o       <= hit_total;
  end

endmodule

FILE: tb/sv/deque_with_value_search_unit_tb.sv
// ----------------------------------------------------------------------------
// Deque with value search unit: testbench top
// Drives directed and random request beats through the deque, with random
// stalls on both channels, a long result hold-off and drain pauses, and
// leaves prediction and comparison to the result checker.
// ----------------------------------------------------------------------------
module deque_with_value_search_unit_tb
  import deqs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 16;
  localparam int RandomPerPhase = 260;
  localparam int TrendLen       = 40;
  localparam int HoldCycles     = 80;
  localparam int SettleCycles   = 40;
  localparam int WatchdogLimit  = 2000;
  localparam int PoolSize       = 8;

  // Codes beyond the defined requests; the block must answer them as no-ops.
  localparam logic [ReqW-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [ReqW-1:0] REQ_SPARE_HI = 3'd7;

  typedef enum int {
    TREND_GROW,
    TREND_SHRINK,
    TREND_MIXED
  } trend_e;

  // Percent thresholds per trend: push, then pop, then remove, then contains.
  int push_lim[3] = '{60, 20, 35};
  int pop_lim[3]  = '{72, 65, 60};
  int rem_lim[3]  = '{84, 85, 77};
  int has_lim[3]  = '{97, 97, 97};

  logic [DataW-1:0] value_pool[PoolSize] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd42
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [ReqW-1:0]  req_type_i  = '0;
  logic [DataW-1:0] value_i     = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       status_o;
  logic [DataW-1:0] popped_value_o;
  logic             found_o;
  logic [OccW-1:0]  occupancy_o;

  int fail_count;
  int pending;
  int results;
  int full_refusals;
  int empty_pops;
  int value_hits;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count    = 0;
  int hold_at       = -1;
  int hold_left     = 0;
  bit hold_fired    = 1'b0;
  int quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  deque_with_value_search_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .value_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .popped_value_o,
    .found_o,
    .occupancy_o
  );

  deque_search_result_check #(
    .DEPTH(DEPTH)
  ) result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .popped_value_i (popped_value_o),
    .found_i        (found_o),
    .occupancy_i    (occupancy_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .full_refusals_o(full_refusals),
    .empty_pops_o   (empty_pops),
    .matches_o      (value_hits)
  );

  // Result side stall: random, except for one long hold-off that lets the
  // deque back up and stall its request side.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_fired && hold_at >= 0 && sent_count >= hold_at) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles - 1;
      hold_fired  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("No beat moved for %0d cycles.", WatchdogLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [ReqW-1:0] req, input logic [DataW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count <= sent_count + 1;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [ReqW-1:0] pick_request(input trend_e trend);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_lim[trend]) return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if (roll < pop_lim[trend]) return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    if (roll < rem_lim[trend]) return REQ_REMOVE;
    if (roll < has_lim[trend]) return REQ_CONTAINS;
    return $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
  endfunction

  // A small pool keeps duplicates and hits common; the rest is full range.
  function automatic logic [DataW-1:0] pick_value();
    if ($urandom_range(99) < 65) return value_pool[$urandom_range(PoolSize - 1)];
    return $urandom();
  endfunction

  initial begin
    send_idle_pct = 35;
    recv_idle_pct = 77;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty deque: both pops fail, searches miss, spare codes do nothing.
    send_request(REQ_POP_FRONT, $urandom());
    send_request(REQ_POP_BACK, $urandom());
    send_request(REQ_REMOVE, 32'h0000_0000);
    send_request(REQ_CONTAINS, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_LO, $urandom());
    send_request(REQ_SPARE_HI, $urandom());
    // Extremes at both ends, with a duplicate of the largest value.
    send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h0000_0000);
    send_request(REQ_CONTAINS, 32'h8000_0000);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF);
    send_request(REQ_CONTAINS, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, 32'h1234_5678);
    send_request(REQ_SPARE_HI, 32'hFFFF_FFFF);
    send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_POP_BACK, 32'hFFFF_FFFF);
    send_request(REQ_CONTAINS, 32'h0000_0000);
    send_request(REQ_POP_BACK, $urandom());
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 77;
        recv_idle_pct = 35;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_at       = sent_count + 30;
      end
      for (int n = 0; n < RandomPerPhase; n++) begin
        send_request(pick_request(trend_e'((n / TrendLen) % 3)), pick_value());
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    $display("%0d requests sent and %0d result beats checked under three stall mixes.",
             sent_count, results);
    $display("Full-deque refusals %0d, empty pops %0d, value matches %0d.",
             full_refusals, empty_pops, value_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
